>>> rtl/spad_pkg.sv
package spad_pkg;

   localparam int CFG_WIDTH  = 24;
   localparam int SUM_WIDTH  = 48;
   localparam int WSUM_WIDTH = 56;
   localparam int TIME_WIDTH = 32;
   localparam int WIN_WIDTH  = 5;

   localparam logic [1:0] CSR_THRESHOLD_HIGH = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD_LOW  = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT        = 2'd2;
   localparam logic [1:0] CSR_WINDOW         = 2'd3;

   // Detector phases.
   typedef enum logic [3:0] {
      PH_WAIT_PING     = 4'b0001,
      PH_SECOND_LEFT   = 4'b0010,
      PH_SECOND_RIGHT  = 4'b0100,
      PH_WAIT_SILENT   = 4'b1000
   } phase_type;

   // Sequencer states.
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MUL    = 7'b0000010,
      ST_ACC    = 7'b0000100,
      ST_HIST   = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_OUT    = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   typedef struct packed {
      logic start;      // latch sample, run timeout and phase decode
      logic mul;        // register products
      logic acc;        // accumulate, decide ping end
      logic hist;       // update history and totals
      logic div_start;  // load the divider
      logic div_step;   // one quotient bit
      logic publish;    // load output register
   } cmd_type;

   typedef struct packed {
      logic ping_end;
      logic div_last;
   } status_type;

endpackage

>>> rtl/spad_datapath.sv
module spad_datapath #(
   parameter int HISTORY_DEPTH = 16,
   parameter int LEVEL_WIDTH   = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [1:0]                     csr_index,
   input  logic [spad_pkg::CFG_WIDTH-1:0] csr_data,
   input  logic [LEVEL_WIDTH-1:0]         left_level,
   input  logic [LEVEL_WIDTH-1:0]         right_level,
   input  spad_pkg::cmd_type              cmd,
   output spad_pkg::status_type           status,
   output logic [23:0]                    left_amplitude,
   output logic [23:0]                    right_amplitude,
   output logic [31:0]                    arrival_difference,
   output logic [47:0]                    left_level_sum,
   output logic [47:0]                    right_level_sum,
   output logic [55:0]                    left_time_weighted,
   output logic [55:0]                    right_time_weighted
);
   import spad_pkg::*;

   localparam int SLOT_WIDTH  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int TOTAL_WIDTH = LEVEL_WIDTH + $clog2(HISTORY_DEPTH + 1);
   localparam int QCNT_WIDTH  = $clog2(TOTAL_WIDTH + 1);
   localparam int PROD_WIDTH  = TIME_WIDTH + LEVEL_WIDTH;
   localparam logic [SUM_WIDTH-1:0]  SUM_MAX  = '1;
   localparam logic [WSUM_WIDTH-1:0] WSUM_MAX = '1;

   logic [CFG_WIDTH-1:0] thr_high_ff, thr_low_ff, timeout_ff;
   logic [WIN_WIDTH-1:0] window_ff;
   phase_type            phase_ff, phase_in;
   logic [CFG_WIDTH-1:0] tmo_rem_ff, tmo_rem_in;
   logic [TIME_WIDTH-1:0] count_ff, count_in;
   logic [TIME_WIDTH-1:0] larr_ff, larr_in, rarr_ff, rarr_in;
   logic [LEVEL_WIDTH-1:0] lpeak_ff, rpeak_ff;
   logic [SUM_WIDTH-1:0]  lsum_ff, rsum_ff;
   logic [WSUM_WIDTH-1:0] lwsum_ff, rwsum_ff;
   logic [LEVEL_WIDTH-1:0] lvl_l_ff, lvl_r_ff;
   logic acc_l_ff, acc_r_ff, move_l_ff, ping_end_ff, silent_ff;
   logic [TIME_WIDTH-1:0] dt_l_ff, dt_r_ff;
   logic [PROD_WIDTH-1:0] prod_l_ff, prod_r_ff;
   logic [LEVEL_WIDTH-1:0] lhist [HISTORY_DEPTH];
   logic [LEVEL_WIDTH-1:0] rhist [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hvalid_ff;
   logic [TOTAL_WIDTH-1:0] ltot_ff, rtot_ff;
   logic [SLOT_WIDTH-1:0] slot_ff;
   logic [WIN_WIDTH-1:0] win_eff;
   logic [TOTAL_WIDTH-1:0] lrem_ff, rrem_ff, lquo_ff, rquo_ff;
   logic [QCNT_WIDTH-1:0] qcnt_ff;
   logic [23:0] lamp_ff, ramp_ff;
   logic [31:0] adiff_ff;
   logic [47:0] olsum_ff, orsum_ff;
   logic [55:0] olw_ff, orw_ff;
   logic [TIME_WIDTH-1:0] larr_in_acc;
   logic [LEVEL_WIDTH-1:0] lpeak_next, rpeak_next;
   logic [SLOT_WIDTH-1:0] slot_use, slot_nxt;
   logic [LEVEL_WIDTH-1:0] lold, rold;

   always_comb begin
      if (window_ff == '0) begin
         win_eff = WIN_WIDTH'(1);
      end else if (32'(window_ff) > HISTORY_DEPTH) begin
         win_eff = WIN_WIDTH'(HISTORY_DEPTH);
      end else begin
         win_eff = window_ff;
      end
   end

   // Phase decode of one sample, before the accumulations.
   logic ld, rd;
   phase_type ph_eff;
   always_comb begin
      count_in   = count_ff + 1'b1;
      tmo_rem_in = tmo_rem_ff;
      ph_eff     = phase_ff;
      if (tmo_rem_ff != '0) begin
         tmo_rem_in = tmo_rem_ff - 1'b1;
         if (tmo_rem_in == '0) begin
            ph_eff = PH_WAIT_SILENT;
         end
      end
      ld       = 32'(left_level) > 32'(thr_high_ff);
      rd       = 32'(right_level) > 32'(thr_high_ff);
      phase_in = ph_eff;
      larr_in  = larr_ff;
      rarr_in  = rarr_ff;
      unique case (ph_eff)
         PH_WAIT_PING: begin
            tmo_rem_in = timeout_ff;
            if (ld) begin
               larr_in  = count_in;
               phase_in = PH_SECOND_RIGHT;
            end
            if (rd) begin
               rarr_in  = count_in;
               phase_in = PH_SECOND_LEFT;
            end
            if (ld && rd) begin
               phase_in = PH_WAIT_SILENT;
            end
         end
         PH_SECOND_LEFT: begin
            if (ld) begin
               larr_in  = count_in;
               phase_in = PH_WAIT_SILENT;
            end
         end
         PH_SECOND_RIGHT: begin
            if (rd) begin
               rarr_in  = count_in;
               phase_in = PH_WAIT_SILENT;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_high_ff <= '0;
         thr_low_ff  <= '0;
         timeout_ff  <= '0;
         window_ff   <= WIN_WIDTH'(10);
         phase_ff    <= PH_WAIT_PING;
         tmo_rem_ff  <= '0;
         count_ff    <= '0;
         larr_ff     <= '0;
         rarr_ff     <= '0;
         hvalid_ff   <= '0;
         ltot_ff     <= '0;
         rtot_ff     <= '0;
         slot_ff     <= '0;
         ping_end_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_THRESHOLD_HIGH: thr_high_ff <= csr_data;
               CSR_THRESHOLD_LOW:  thr_low_ff  <= csr_data;
               CSR_TIMEOUT:        timeout_ff  <= csr_data;
               CSR_WINDOW: begin
                  window_ff <= csr_data[WIN_WIDTH-1:0];
                  hvalid_ff <= '0;
                  ltot_ff   <= '0;
                  rtot_ff   <= '0;
                  slot_ff   <= '0;
               end
               default: ;
            endcase
         end
         if (cmd.start) begin
            count_ff   <= count_in;
            tmo_rem_ff <= tmo_rem_in;
            phase_ff   <= phase_in;
            larr_ff    <= larr_in;
            rarr_ff    <= rarr_in;
         end
         if (cmd.acc) begin
            if (move_l_ff && (lpeak_next == lvl_l_ff)) begin
               larr_ff <= count_ff;
            end
            ping_end_ff <= silent_ff
               && (32'(lvl_l_ff) < 32'(thr_low_ff))
               && (32'(lvl_r_ff) < 32'(thr_low_ff));
            if (silent_ff
                && (32'(lvl_l_ff) < 32'(thr_low_ff))
                && (32'(lvl_r_ff) < 32'(thr_low_ff))) begin
               phase_ff <= PH_WAIT_PING;
            end
         end
         if (cmd.hist) begin
            hvalid_ff[slot_use] <= 1'b1;
            ltot_ff <= ltot_ff - TOTAL_WIDTH'(lold) + TOTAL_WIDTH'(lpeak_ff);
            rtot_ff <= rtot_ff - TOTAL_WIDTH'(rold) + TOTAL_WIDTH'(rpeak_ff);
            slot_ff <= slot_nxt;
         end
      end
   end

   // Sample registers and products: dt times level, one multiplier per side.
   // The silence check runs only for samples that began in wait-for-silence.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         lvl_l_ff  <= left_level;
         lvl_r_ff  <= right_level;
         acc_l_ff  <= (ph_eff != PH_WAIT_PING) ? (ph_eff != PH_SECOND_LEFT) || ld : ld;
         acc_r_ff  <= (ph_eff != PH_WAIT_PING) ? (ph_eff != PH_SECOND_RIGHT) || rd : rd;
         move_l_ff <= (ph_eff == PH_SECOND_RIGHT);
         silent_ff <= (ph_eff == PH_WAIT_SILENT);
         dt_l_ff   <= count_in - larr_in_acc;
         dt_r_ff   <= count_in - rarr_in;
      end
      if (cmd.mul) begin
         prod_l_ff <= PROD_WIDTH'(dt_l_ff) * PROD_WIDTH'(lvl_l_ff);
         prod_r_ff <= PROD_WIDTH'(dt_r_ff) * PROD_WIDTH'(lvl_r_ff);
      end
   end

   // In second-right the left weight uses the arrival before any move.
   assign larr_in_acc = larr_in;

   // Peak and sum updates.
   logic [SUM_WIDTH:0]  lsum_w, rsum_w;
   logic [WSUM_WIDTH:0] lw_w, rw_w;
   logic [WSUM_WIDTH-1:0] lprod_s, rprod_s;
   always_comb begin
      lpeak_next = (acc_l_ff && lvl_l_ff > lpeak_ff) ? lvl_l_ff : lpeak_ff;
      rpeak_next = (acc_r_ff && lvl_r_ff > rpeak_ff) ? lvl_r_ff : rpeak_ff;
      lsum_w = {1'b0, lsum_ff} + (SUM_WIDTH + 1)'(lvl_l_ff);
      rsum_w = {1'b0, rsum_ff} + (SUM_WIDTH + 1)'(lvl_r_ff);
      lprod_s = (PROD_WIDTH > WSUM_WIDTH && |(prod_l_ff >> WSUM_WIDTH))
         ? WSUM_MAX : WSUM_WIDTH'(prod_l_ff);
      rprod_s = (PROD_WIDTH > WSUM_WIDTH && |(prod_r_ff >> WSUM_WIDTH))
         ? WSUM_MAX : WSUM_WIDTH'(prod_r_ff);
      lw_w = {1'b0, lwsum_ff} + (WSUM_WIDTH + 1)'(lprod_s);
      rw_w = {1'b0, rwsum_ff} + (WSUM_WIDTH + 1)'(rprod_s);
   end

   always_ff @(posedge clock) begin
      if (cmd.start && ph_eff == PH_WAIT_PING) begin
         lpeak_ff <= '0;
         rpeak_ff <= '0;
         lsum_ff  <= '0;
         rsum_ff  <= '0;
         lwsum_ff <= '0;
         rwsum_ff <= '0;
      end else if (cmd.acc) begin
         lpeak_ff <= lpeak_next;
         rpeak_ff <= rpeak_next;
         if (acc_l_ff) begin
            lsum_ff  <= lsum_w[SUM_WIDTH] ? SUM_MAX : lsum_w[SUM_WIDTH-1:0];
            lwsum_ff <= lw_w[WSUM_WIDTH] ? WSUM_MAX : lw_w[WSUM_WIDTH-1:0];
         end
         if (acc_r_ff) begin
            rsum_ff  <= rsum_w[SUM_WIDTH] ? SUM_MAX : rsum_w[SUM_WIDTH-1:0];
            rwsum_ff <= rw_w[WSUM_WIDTH] ? WSUM_MAX : rw_w[WSUM_WIDTH-1:0];
         end
      end
   end

   // History ring.
   always_comb begin
      slot_use = (32'(slot_ff) >= 32'(win_eff)) ? '0 : slot_ff;
      slot_nxt = (32'(slot_use) + 1 >= 32'(win_eff)) ? '0 : SLOT_WIDTH'(slot_use + 1'b1);
      lold = hvalid_ff[slot_use] ? lhist[slot_use] : '0;
      rold = hvalid_ff[slot_use] ? rhist[slot_use] : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.hist) begin
         lhist[slot_use] <= lpeak_ff;
         rhist[slot_use] <= rpeak_ff;
      end
   end

   // Restoring divider, one quotient bit per cycle for both sides.
   logic [TOTAL_WIDTH:0] ltry, rtry;
   always_comb begin
      ltry = {lrem_ff, lquo_ff[TOTAL_WIDTH-1]} - (TOTAL_WIDTH + 1)'(win_eff);
      rtry = {rrem_ff, rquo_ff[TOTAL_WIDTH-1]} - (TOTAL_WIDTH + 1)'(win_eff);
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         lrem_ff <= '0;
         rrem_ff <= '0;
         lquo_ff <= ltot_ff;
         rquo_ff <= rtot_ff;
         qcnt_ff <= QCNT_WIDTH'(TOTAL_WIDTH);
      end else if (cmd.div_step) begin
         qcnt_ff <= qcnt_ff - 1'b1;
         if (!ltry[TOTAL_WIDTH]) begin
            lrem_ff <= ltry[TOTAL_WIDTH-1:0];
         end else begin
            lrem_ff <= {lrem_ff[TOTAL_WIDTH-2:0], lquo_ff[TOTAL_WIDTH-1]};
         end
         if (!rtry[TOTAL_WIDTH]) begin
            rrem_ff <= rtry[TOTAL_WIDTH-1:0];
         end else begin
            rrem_ff <= {rrem_ff[TOTAL_WIDTH-2:0], rquo_ff[TOTAL_WIDTH-1]};
         end
         lquo_ff <= {lquo_ff[TOTAL_WIDTH-2:0], ~ltry[TOTAL_WIDTH]};
         rquo_ff <= {rquo_ff[TOTAL_WIDTH-2:0], ~rtry[TOTAL_WIDTH]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         lamp_ff  <= (TOTAL_WIDTH > 24 && |(lquo_ff >> 24)) ? 24'hFFFFFF : 24'(lquo_ff);
         ramp_ff  <= (TOTAL_WIDTH > 24 && |(rquo_ff >> 24)) ? 24'hFFFFFF : 24'(rquo_ff);
         adiff_ff <= rarr_ff - larr_ff;
         olsum_ff <= lsum_ff;
         orsum_ff <= rsum_ff;
         olw_ff   <= lwsum_ff;
         orw_ff   <= rwsum_ff;
      end
   end

   assign status.ping_end = ping_end_ff;
   assign status.div_last = (qcnt_ff == QCNT_WIDTH'(1));

   assign left_amplitude      = lamp_ff;
   assign right_amplitude     = ramp_ff;
   assign arrival_difference  = adiff_ff;
   assign left_level_sum      = olsum_ff;
   assign right_level_sum     = orsum_ff;
   assign left_time_weighted  = olw_ff;
   assign right_time_weighted = orw_ff;

endmodule

>>> rtl/spad_control.sv
module spad_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  spad_pkg::status_type status,
   output spad_pkg::cmd_type    cmd
);
   import spad_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cmd      = '0;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      req_tready = (state_ff == ST_IDLE) && !reset;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !reset) begin
               cmd.start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_HIST;
         end
         ST_HIST: begin
            if (status.ping_end) begin
               cmd.hist = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               valid_in    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

>>> rtl/stereo_ping_arrival_detector.sv
// Stereo ping arrival detector.
// The req_ channel carries one pair of left and right tone levels per transfer.
// The detector waits for a level above the high threshold, then for the second
// channel or a timeout, then until both channels fall below the low threshold.
// At that ping end one transfer leaves on the rsp_ channel with the arrival
// difference, saturating level sums, time-weighted sums and the moving average
// of recent peaks. Samples that do not end a ping produce no transfer.
// An ordinary sample passes the multiply, accumulate and history check before
// the next ready. A ping end adds the history update and a restoring divide of
// one quotient bit per cycle over the width of the history totals.
// The result sits in an output register; while the receiver stalls, further
// samples are still taken, and only the next ping end waits for it to drain.
// The csr_ port writes a register directly from csr_write; write it only while idle.
// A window write clears the peak history. Reset is synchronous and restores
// the control registers, sequencer state and response valid, with a window of ten.
module stereo_ping_arrival_detector #(
   parameter int HISTORY_DEPTH = 16,
   parameter int LEVEL_WIDTH   = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // left_level, right_level
   input  logic [2*LEVEL_WIDTH-1:0]        req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // left_amplitude, right_amplitude, arrival_difference, left_level_sum,
   // right_level_sum, left_time_weighted, right_time_weighted
   output logic [287:0]                    rsp_tdata,
   input  logic                            csr_write,
   input  logic [1:0]                      csr_index,
   input  logic [spad_pkg::CFG_WIDTH-1:0]  csr_data
);
   import spad_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [23:0] lamp, ramp;
   logic [31:0] adiff;
   logic [47:0] lsum, rsum;
   logic [55:0] lw, rw;

   spad_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   spad_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .LEVEL_WIDTH   (LEVEL_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .left_level          (req_tdata[LEVEL_WIDTH-1:0]),
      .right_level         (req_tdata[2*LEVEL_WIDTH-1:LEVEL_WIDTH]),
      .cmd                 (cmd),
      .status              (status),
      .left_amplitude      (lamp),
      .right_amplitude     (ramp),
      .arrival_difference  (adiff),
      .left_level_sum      (lsum),
      .right_level_sum     (rsum),
      .left_time_weighted  (lw),
      .right_time_weighted (rw)
   );

   assign rsp_tdata = {rw, lw, rsum, lsum, adiff, ramp, lamp};

endmodule
